/* rtl/core/set_assoc_cache_lru_lfu_sim_defines.svh */
// Assertion macros shared by the cache checker.
// Depends on nothing; each macro expects signal clk in scope, and SCACHE_ASSERT also rst.
`ifndef SET_ASSOC_CACHE_LRU_LFU_SIM_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_LFU_SIM_DEFINES_SVH

// Clocked property, switched off while reset is high.
`define SCACHE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds during reset.
`define SCACHE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/scache_pkg.sv */
// Shared constants for the set-associative cache model.
// No dependencies.
package scache_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W      = 32;
  localparam int USE_W      = 16;
  localparam int SETIDX_W   = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_CYCLES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_CYCLES = 3'd5;

  localparam logic POLICY_LRU = 1'b0;
  localparam logic POLICY_LFU = 1'b1;

endpackage

/* rtl/core/set_assoc_cache_lru_lfu_sim.sv */
// Set-associative cache hit/miss model, LRU or LFU replacement.
// Depends on scache_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   request | req_valid/req_ready  | address
//   result  | rsp_valid/rsp_ready  | hit, total_accesses, total_hits,
//           |                      | total_cycles
//   config  | cfg_we               | cfg_index, cfg_data
//
// A request passes accept and set read, then compare and write-back, when
// MAX_SETS is a power of two; otherwise the quotient and remainder states
// reduce the set index by reciprocal multiply before the set read.
// After reset a clearing pass writes every set row, with req_ready low.
// A stalled result holds the compare stage until taken.
module set_assoc_cache_lru_lfu_sim #(
  parameter int MAX_SETS   = 1024,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [ADDR_WIDTH-1:0]              address,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic                               hit,
  output logic [scache_pkg::CNT_W-1:0]       total_accesses,
  output logic [scache_pkg::CNT_W-1:0]       total_hits,
  output logic [scache_pkg::CNT_W-1:0]       total_cycles,
  input  logic                               cfg_we,
  input  logic [scache_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scache_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import scache_pkg::*;

  localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WC_W      = $clog2(MAX_WAYS + 1);
  localparam bit SETS_POW2 = (MAX_SETS & (MAX_SETS - 1)) == 0;
  localparam logic [15:0] SET_MASK = 16'(MAX_SETS - 1);
  localparam logic [32:0] RECIP    = 33'(((64'd1 << 32) + MAX_SETS - 1) / MAX_SETS);
  localparam logic [16:0] SETS_K   = 17'(MAX_SETS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_QUOT = 2'd1;
  localparam logic [1:0] S_REM  = 2'd2;
  localparam logic [1:0] S_LOOK = 2'd3;

  typedef struct packed {
    logic                  valid;
    logic [ADDR_WIDTH-1:0] tag;
    logic [CNT_W-1:0]      stamp;
    logic [USE_W-1:0]      count;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  // Configuration registers.
  logic        policy;
  logic [3:0]  ways_used;
  logic [3:0]  set_bits;
  logic [4:0]  offset_bits;
  logic [15:0] hit_cycles;
  logic [15:0] miss_cycles;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POLICY_LRU;
      ways_used   <= 4'd1;
      set_bits    <= 4'd0;
      offset_bits <= 5'd0;
      hit_cycles  <= 16'd1;
      miss_cycles <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY:      policy      <= cfg_data[0];
        CFG_WAYS_USED:   ways_used   <= cfg_data[3:0];
        CFG_SET_BITS:    set_bits    <= cfg_data[3:0];
        CFG_OFFSET_BITS: offset_bits <= cfg_data[4:0];
        CFG_HIT_CYCLES:  hit_cycles  <= cfg_data;
        CFG_MISS_CYCLES: miss_cycles <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state.
  logic [1:0]       state, state_next;
  logic             clr_busy;
  logic [SET_W-1:0] clr_idx;
  logic             accept;
  logic             finish;

  // Per-request registers.
  logic [ADDR_WIDTH-1:0] tag_r;
  logic [SETIDX_W-1:0]   sidx_r;
  logic [15:0]           quot_r;
  logic [SET_W-1:0]      set_r;

  // Address split: drop offset bits, mask the set field, keep the rest as tag.
  logic [ADDR_WIDTH-1:0] above;
  logic [SETIDX_W-1:0]   set_field;
  logic [ADDR_WIDTH-1:0] tag_in;
  logic [SET_W-1:0]      set_pow2;
  logic [47:0]           quot_prod;
  logic [32:0]           rem_prod;
  logic [SET_W-1:0]      set_rem;

  always_comb begin
    above     = address >> offset_bits;
    set_field = above[SETIDX_W-1:0] & ((SETIDX_W'(1) << set_bits) - SETIDX_W'(1));
    tag_in    = above >> set_bits;
    set_pow2  = SET_W'({1'b0, set_field} & SET_MASK);
    quot_prod = 48'(sidx_r) * 48'(RECIP);
    rem_prod  = 33'(quot_r) * 33'(SETS_K);
    set_rem   = SET_W'(33'(sidx_r) - rem_prod);
  end

  // Set memory: one row holds every way of a set.
  row_t             mem [MAX_SETS];
  row_t             rd_row;
  row_t             wb_row;
  logic             rd_en;
  logic [SET_W-1:0] rd_idx;

  always_comb begin
    rd_en  = 1'b0;
    rd_idx = set_pow2;
    if (SETS_POW2) begin
      rd_en = accept;
    end else begin
      rd_en  = (state == S_REM);
      rd_idx = set_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_idx] <= '0;
    end else if (finish) begin
      mem[set_r] <= wb_row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_idx];
    end
  end

  // Lookup, victim choice and row update.
  logic [WC_W-1:0]  ways_eff;
  logic             hit_now;
  logic [WAY_W-1:0] hit_way;
  logic             free_found;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] min_way;
  logic [CNT_W-1:0] best;
  logic [CNT_W-1:0] key;
  logic [WAY_W-1:0] fill_way;

  always_comb begin
    if (ways_used == 4'd0) begin
      ways_eff = WC_W'(1);
    end else if (int'(ways_used) > MAX_WAYS) begin
      ways_eff = WC_W'(MAX_WAYS);
    end else begin
      ways_eff = WC_W'(ways_used);
    end

    hit_now    = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < int'(ways_eff)) begin
        if (rd_row[w].valid && rd_row[w].tag == tag_r) begin
          hit_now = 1'b1;
          hit_way = WAY_W'(w);
        end
        if (!rd_row[w].valid) begin
          free_found = 1'b1;
          free_way   = WAY_W'(w);
        end
      end
    end

    // Lowest key wins, ties to the lower way.
    best    = (policy == POLICY_LFU) ? CNT_W'(rd_row[0].count) : rd_row[0].stamp;
    min_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      key = (policy == POLICY_LFU) ? CNT_W'(rd_row[w].count) : rd_row[w].stamp;
      if (w < int'(ways_eff) && key < best) begin
        best    = key;
        min_way = WAY_W'(w);
      end
    end

    fill_way = free_found ? free_way : min_way;
    wb_row   = rd_row;
    if (hit_now) begin
      if (policy == POLICY_LRU) begin
        wb_row[hit_way].stamp = total_accesses;
      end else if (rd_row[hit_way].count != '1) begin
        wb_row[hit_way].count = rd_row[hit_way].count + USE_W'(1);
      end
    end else begin
      wb_row[fill_way].valid = 1'b1;
      wb_row[fill_way].tag   = tag_r;
      if (policy == POLICY_LRU) begin
        wb_row[fill_way].stamp = total_accesses;
      end else begin
        wb_row[fill_way].count = USE_W'(1);
      end
    end
  end

  // Sequencer.
  assign req_ready = (state == S_IDLE) && !clr_busy;
  assign accept    = req_valid && req_ready;
  assign finish    = (state == S_LOOK) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = SETS_POW2 ? S_LOOK : S_QUOT;
      end
      S_QUOT: state_next = S_REM;
      S_REM:  state_next = S_LOOK;
      S_LOOK: begin
        if (finish) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else begin
      state <= state_next;
      if (clr_busy) begin
        clr_idx <= clr_idx + SET_W'(1);
        if (clr_idx == SET_W'(MAX_SETS - 1)) clr_busy <= 1'b0;
      end
    end
  end

  // Hold request fields; quotient for the non power-of-two reduction.
  always_ff @(posedge clk) begin
    if (accept) begin
      tag_r  <= tag_in;
      sidx_r <= set_field;
      set_r  <= set_pow2;
    end
    if (state == S_QUOT) begin
      quot_r <= quot_prod[47:32];
    end
    if (state == S_REM) begin
      set_r <= set_rem;
    end
  end

  // Totals and result register; saturate every counter.
  logic [CNT_W+1:0] cyc_sum;

  always_comb begin
    cyc_sum = (CNT_W+2)'(total_cycles) + (CNT_W+2)'(hit_cycles)
            + (hit_now ? '0 : (CNT_W+2)'(miss_cycles));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid      <= 1'b0;
      hit            <= 1'b0;
      total_accesses <= '0;
      total_hits     <= '0;
      total_cycles   <= '0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      if (finish) begin
        rsp_valid <= 1'b1;
        hit       <= hit_now;
        if (total_accesses != '1) total_accesses <= total_accesses + CNT_W'(1);
        if (hit_now && total_hits != '1) total_hits <= total_hits + CNT_W'(1);
        total_cycles <= (cyc_sum > (CNT_W+2)'({CNT_W{1'b1}})) ? '1 : cyc_sum[CNT_W-1:0];
      end
    end
  end

endmodule

/* rtl/core/scache_checker.sv */
// Port-level checks for the cache model, bound to the top level.
// Depends on scache_pkg and set_assoc_cache_lru_lfu_sim_defines.svh.
`include "set_assoc_cache_lru_lfu_sim_defines.svh"

module scache_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         hit,
  input logic [scache_pkg::CNT_W-1:0] total_accesses,
  input logic [scache_pkg::CNT_W-1:0] total_hits
);
  import scache_pkg::*;

  // One request at a time: ready drops after an accept.
  `SCACHE_ASSERT(a_one_at_a_time, (req_valid && req_ready) |=> !req_ready, "ready after accept")
  // A held result stays valid and keeps its access total.
  `SCACHE_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(total_accesses)), "result changed while stalled")
  // Hits never outrun accesses.
  `SCACHE_ASSERT(a_hits_le_acc, rsp_valid |-> (total_hits <= total_accesses), "hits above accesses")
  // A hit result carries a nonzero hit total.
  `SCACHE_ASSERT(a_hit_counted, (rsp_valid && hit) |-> (total_hits != '0), "hit not counted")

endmodule

bind set_assoc_cache_lru_lfu_sim scache_checker u_scache_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req_valid),
  .req_ready      (req_ready),
  .rsp_valid      (rsp_valid),
  .rsp_ready      (rsp_ready),
  .hit            (hit),
  .total_accesses (total_accesses),
  .total_hits     (total_hits)
);
